// File: sv/dust_fan_mode_controller_unit_macros.svh
// -----------------------------------------------------------------------------
// dust_fan_mode_controller_unit_macros.svh
// Assertion macros for the checker file dfmc_checker.sv.
// -----------------------------------------------------------------------------
`ifndef DUST_FAN_MODE_CONTROLLER_UNIT_MACROS_SVH
`define DUST_FAN_MODE_CONTROLLER_UNIT_MACROS_SVH

// Clocked assertion, muted while reset is high.
`define DFMC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define DFMC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/dfmc_pkg.sv
// -----------------------------------------------------------------------------
// dfmc_pkg
// Widths, codes and helpers for the dust fan mode controller.
// -----------------------------------------------------------------------------
package dfmc_pkg;

  localparam int TIMER_BITS = 24;
  localparam int DUST_BITS  = 16;

  // config data is as wide as the widest register
  localparam int CFG_DATA_W = (TIMER_BITS > DUST_BITS) ? TIMER_BITS : DUST_BITS;
  localparam int CFG_IDX_W  = 3;

  // stream word widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((DUST_BITS + 7) / 8) * 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_FIELD_W = 3;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [DUST_BITS-1:0]  dust_t;

  typedef enum logic [1:0] {
    MODE_AUTO   = 2'd0,
    MODE_MANUAL = 2'd1,
    MODE_OFF    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CMD_TICK          = 2'd0,
    CMD_DUST          = 2'd1,
    CMD_TOGGLE_MANUAL = 2'd2,
    CMD_TOGGLE_OFF    = 2'd3
  } cmd_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DUST_ON_LEVEL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUST_OFF_LEVEL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN_TICKS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MANUAL_HIGH_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_MODE        = 3'd4;

  // register reset values
  localparam dust_t  DUST_ON_LEVEL_RST     = DUST_BITS'(150);
  localparam dust_t  DUST_OFF_LEVEL_RST    = DUST_BITS'(100);
  localparam timer_t MIN_RUN_TICKS_RST     = TIMER_BITS'(300);
  localparam timer_t MANUAL_HIGH_TICKS_RST = TIMER_BITS'(1800);
  localparam logic [1:0] RESET_MODE_RST    = 2'd0;

  // code three maps to auto
  function automatic mode_t legal_mode(input logic [1:0] code);
    mode_t m;
    case (code)
      MODE_MANUAL: m = MODE_MANUAL;
      MODE_OFF:    m = MODE_OFF;
      default:     m = MODE_AUTO;
    endcase
    return m;
  endfunction

  function automatic timer_t count_up(input timer_t c);
    return (c == '1) ? c : c + TIMER_BITS'(1);
  endfunction

endpackage

// File: sv/dust_fan_mode_controller_unit.sv
// -----------------------------------------------------------------------------
// dust_fan_mode_controller_unit: input register, then state update, then result register.
// Throughput one word per cycle unless the result stream stalls; set by the single state update stage.
// rst (sync, high) clears both stages, mode auto, fan off, run timer saturated.
// -----------------------------------------------------------------------------
module dust_fan_mode_controller_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  // input stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [dfmc_pkg::IN_TDATA_W-1:0]        s_axis_tdata,  // [15:0] dust_level
  input  logic [dfmc_pkg::IN_TUSER_W-1:0]        s_axis_tuser,  // [1:0] command
  // result stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [dfmc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // [0] fan_on, [2:1] mode
  // configuration write port
  input  logic                                   cfg_we,
  input  logic [dfmc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dfmc_pkg::CFG_DATA_W-1:0]        cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  dfmc_pkg::dust_t  dust_on_level;
  dfmc_pkg::dust_t  dust_off_level;
  dfmc_pkg::timer_t min_run_ticks;
  dfmc_pkg::timer_t manual_high_ticks;

  // ---------------------------------------------------------------------------
  // Controller state
  // ---------------------------------------------------------------------------
  dfmc_pkg::mode_t  mode_reg, mode_reg_next;
  logic             fan_reg, fan_reg_next;
  dfmc_pkg::timer_t run_elapsed, run_elapsed_next;
  dfmc_pkg::timer_t manual_elapsed, manual_elapsed_next;

  // ---------------------------------------------------------------------------
  // Pipeline: input register -> update -> result register
  // ---------------------------------------------------------------------------
  logic             in_valid;
  dfmc_pkg::cmd_t   in_cmd;
  dfmc_pkg::dust_t  in_dust;

  logic             out_valid;
  logic             out_fan;
  dfmc_pkg::mode_t  out_mode;

  logic             advance;   // input stage moves into the result register
  logic             s_accept;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(dfmc_pkg::OUT_TDATA_W - dfmc_pkg::OUT_FIELD_W){1'b0}},
                          out_mode, out_fan};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_cmd  <= dfmc_pkg::cmd_t'(s_axis_tuser[1:0]);
      in_dust <= s_axis_tdata[dfmc_pkg::DUST_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // One event update, in the order: tick/toggle, manual timeout, auto dust
  // decision, manual forces fan on.
  // ---------------------------------------------------------------------------
  always_comb begin
    mode_reg_next       = mode_reg;
    fan_reg_next        = fan_reg;
    run_elapsed_next    = run_elapsed;
    manual_elapsed_next = manual_elapsed;

    case (in_cmd)
      dfmc_pkg::CMD_TICK: begin
        run_elapsed_next    = dfmc_pkg::count_up(run_elapsed);
        manual_elapsed_next = dfmc_pkg::count_up(manual_elapsed);
      end
      dfmc_pkg::CMD_TOGGLE_MANUAL: begin
        // ignored in off mode
        if (mode_reg == dfmc_pkg::MODE_AUTO) begin
          mode_reg_next       = dfmc_pkg::MODE_MANUAL;
          manual_elapsed_next = '0;
          fan_reg_next        = 1'b1;
        end else if (mode_reg == dfmc_pkg::MODE_MANUAL) begin
          mode_reg_next = dfmc_pkg::MODE_AUTO;
        end
      end
      dfmc_pkg::CMD_TOGGLE_OFF: begin
        // leaving off keeps the fan as it was
        if (mode_reg == dfmc_pkg::MODE_OFF) begin
          mode_reg_next = dfmc_pkg::MODE_AUTO;
        end else begin
          mode_reg_next = dfmc_pkg::MODE_OFF;
          fan_reg_next  = 1'b0;
        end
      end
      default: ;
    endcase

    // manual high expires once the count passes its duration
    if (mode_reg_next == dfmc_pkg::MODE_MANUAL &&
        manual_elapsed_next > manual_high_ticks) begin
      mode_reg_next = dfmc_pkg::MODE_AUTO;
    end

    // auto hysteresis; strict compares, turn-off waits for min run
    if (in_cmd == dfmc_pkg::CMD_DUST && mode_reg_next == dfmc_pkg::MODE_AUTO) begin
      if (!fan_reg_next && in_dust > dust_on_level) begin
        fan_reg_next     = 1'b1;
        run_elapsed_next = '0;
      end else if (fan_reg_next && in_dust < dust_off_level &&
                   run_elapsed_next >= min_run_ticks) begin
        fan_reg_next = 1'b0;
      end
    end

    if (mode_reg_next == dfmc_pkg::MODE_MANUAL) begin
      fan_reg_next = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // State and configuration. The user must write only while idle, so that a reset_mode
  // write never meets an update in the same cycle; the block does not enforce it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      dust_on_level     <= dfmc_pkg::DUST_ON_LEVEL_RST;
      dust_off_level    <= dfmc_pkg::DUST_OFF_LEVEL_RST;
      min_run_ticks     <= dfmc_pkg::MIN_RUN_TICKS_RST;
      manual_high_ticks <= dfmc_pkg::MANUAL_HIGH_TICKS_RST;
      mode_reg          <= dfmc_pkg::legal_mode(dfmc_pkg::RESET_MODE_RST);
      fan_reg           <= 1'b0;
      run_elapsed       <= '1;
      manual_elapsed    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dfmc_pkg::REG_DUST_ON_LEVEL:
          dust_on_level <= cfg_data[dfmc_pkg::DUST_BITS-1:0];
        dfmc_pkg::REG_DUST_OFF_LEVEL:
          dust_off_level <= cfg_data[dfmc_pkg::DUST_BITS-1:0];
        dfmc_pkg::REG_MIN_RUN_TICKS:
          min_run_ticks <= cfg_data[dfmc_pkg::TIMER_BITS-1:0];
        dfmc_pkg::REG_MANUAL_HIGH_TICKS:
          manual_high_ticks <= cfg_data[dfmc_pkg::TIMER_BITS-1:0];
        dfmc_pkg::REG_RESET_MODE: begin
          // acts as a re-init of the mode
          mode_reg       <= dfmc_pkg::legal_mode(cfg_data[1:0]);
          manual_elapsed <= '0;
          fan_reg        <= 1'b0;
        end
        default: ;
      endcase
    end else if (advance) begin
      mode_reg       <= mode_reg_next;
      fan_reg        <= fan_reg_next;
      run_elapsed    <= run_elapsed_next;
      manual_elapsed <= manual_elapsed_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_fan  <= fan_reg_next;
      out_mode <= mode_reg_next;
    end
  end

endmodule

// File: sv/dfmc_checker.sv
// -----------------------------------------------------------------------------
// dfmc_checker
// Port-level checks on the dust fan mode controller, bound to the top level.
// -----------------------------------------------------------------------------
`include "dust_fan_mode_controller_unit_macros.svh"

module dfmc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [dfmc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  // manual high always drives the fan
  `DFMC_ASSERT(a_manual_fan_on, m_axis_tvalid && m_axis_tdata[2:1] == dfmc_pkg::MODE_MANUAL |-> m_axis_tdata[0], "manual mode with fan off")

  // off mode never drives the fan
  `DFMC_ASSERT(a_off_fan_off, m_axis_tvalid && m_axis_tdata[2:1] == dfmc_pkg::MODE_OFF |-> !m_axis_tdata[0], "off mode with fan on")

  // reset flushes any pending result
  `DFMC_ASSERT_ALWAYS(a_reset_flush, $past(rst) |-> !m_axis_tvalid, "result valid after reset")

  // stalled result holds its word
  `DFMC_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind dust_fan_mode_controller_unit dfmc_checker u_dfmc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
